[design/sfcr_pkg.sv]
package sfcr_pkg;

    localparam int IN_FRAME_BYTES  = 5;
    localparam int OUT_FRAME_BYTES = 5;
    localparam int RUN_BEATS       = IN_FRAME_BYTES + OUT_FRAME_BYTES;
    localparam int BEAT_IDX_W      = $clog2(RUN_BEATS);

    localparam logic [7:0] SYNC_BIT   = 8'h80;
    localparam logic [7:0] CHECK_MASK = 8'h7F;
    localparam logic [7:0] CRC_POLY   = 8'h31;
    localparam logic [7:0] CRC_INIT   = 8'hFF;
    localparam logic [7:0] HDR0       = 8'hFF;
    localparam logic [7:0] HDR1       = 8'h02;
    localparam logic [7:0] HDR2       = 8'h14;

    localparam logic CH_ECHO = 1'b0;
    localparam logic CH_CONV = 1'b1;

    // Beat positions within one result run
    localparam logic [BEAT_IDX_W-1:0] BEAT_HDR0 = BEAT_IDX_W'(IN_FRAME_BYTES);
    localparam logic [BEAT_IDX_W-1:0] BEAT_HDR1 = BEAT_IDX_W'(IN_FRAME_BYTES + 1);
    localparam logic [BEAT_IDX_W-1:0] BEAT_HDR2 = BEAT_IDX_W'(IN_FRAME_BYTES + 2);
    localparam logic [BEAT_IDX_W-1:0] BEAT_CONV = BEAT_IDX_W'(IN_FRAME_BYTES + 3);
    localparam logic [BEAT_IDX_W-1:0] BEAT_LAST = BEAT_IDX_W'(RUN_BEATS - 1);

    // One checked frame, ready for the back end
    typedef struct packed {
        logic [IN_FRAME_BYTES-1:0][7:0] echo;
        logic [7:0]                     conv_x;
        logic [7:0]                     crc;
    } sfcr_frame_t;

    typedef struct packed {
        logic        push;
        sfcr_frame_t frame;
    } sfcr_push_t;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] c_in, input logic [7:0] d);
        logic [7:0] c;
        c = c_in ^ d;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // CRC state after the fixed three header bytes
    localparam logic [7:0] CRC_PREFIX = crc8_byte(crc8_byte(crc8_byte(CRC_INIT, HDR0), HDR1), HDR2);

endpackage

[design/sfcr_front.sv]
module sfcr_front
    import sfcr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    output sfcr_push_t push_out
);

    logic [2:0]       fill_count_reg, fill_count_next;
    logic             synced_reg, synced_next;
    logic [3:0][7:0]  store_reg;
    logic             store_we;
    logic [1:0]       store_idx;
    logic             complete;
    logic [7:0]       chk;
    logic [15:0]      conv_wide;

    assign store_idx = fill_count_reg[1:0];
    assign chk       = (store_reg[0] ^ store_reg[1] ^ store_reg[2] ^ store_reg[3]) & CHECK_MASK;
    assign conv_wide = ({8'h00, store_reg[2]} << 7) | {8'h00, store_reg[3]};

    always_comb begin
        fill_count_next = fill_count_reg;
        synced_next     = synced_reg;
        store_we        = 1'b0;
        complete        = 1'b0;
        if (accept) begin
            if ((rx_byte & SYNC_BIT) != 8'h00) begin
                fill_count_next = 3'd1;
                synced_next     = 1'b1;
            end else if (synced_reg && fill_count_reg < 3'(IN_FRAME_BYTES)) begin
                if (fill_count_reg == 3'(IN_FRAME_BYTES - 1)) begin
                    complete        = 1'b1;
                    fill_count_next = 3'd0;
                    synced_next     = 1'b0;
                end else begin
                    store_we        = 1'b1;
                    fill_count_next = fill_count_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg <= 3'd0;
            synced_reg     <= 1'b0;
        end else begin
            fill_count_reg <= fill_count_next;
            synced_reg     <= synced_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (rx_byte & SYNC_BIT) != 8'h00) begin
            store_reg[0] <= rx_byte;
        end else if (store_we) begin
            store_reg[store_idx] <= rx_byte;
        end
    end

    // Drop the frame unless the check byte matches
    always_comb begin
        push_out.push         = complete && (chk == rx_byte);
        push_out.frame.echo   = {rx_byte, store_reg[3], store_reg[2], store_reg[1], store_reg[0]};
        push_out.frame.conv_x = conv_wide[7:0];
        push_out.frame.crc    = crc8_byte(CRC_PREFIX, conv_wide[7:0]);
    end

endmodule

[design/sfcr_fifo.sv]
module sfcr_fifo
    import sfcr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  sfcr_push_t  push_in,
    input  logic        pop,
    output logic        full,
    output logic        not_empty,
    output sfcr_frame_t head
);

    sfcr_frame_t mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push_in.push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push_in.push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_in.push) begin
            mem[wr_ptr_reg] <= push_in.frame;
        end
    end

endmodule

[design/sfcr_back.sv]
module sfcr_back
    import sfcr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        frame_avail,
    input  sfcr_frame_t frame,
    output logic        pop,
    input  logic        m_ready,
    output logic        m_valid,
    output logic        m_channel,
    output logic [7:0]  m_out_byte,
    output logic        m_frame_end
);

    logic [BEAT_IDX_W-1:0] beat_reg, beat_next;
    logic                  valid_reg, valid_next;
    logic                  channel_reg;
    logic [7:0]            byte_reg;
    logic                  end_reg;
    logic                  load;
    logic [7:0]            sel_byte;

    assign load = frame_avail && (!valid_reg || m_ready);
    assign pop  = load && (beat_reg == BEAT_LAST);

    always_comb begin
        case (beat_reg)
            BEAT_HDR0: sel_byte = HDR0;
            BEAT_HDR1: sel_byte = HDR1;
            BEAT_HDR2: sel_byte = HDR2;
            BEAT_CONV: sel_byte = frame.conv_x;
            BEAT_LAST: sel_byte = frame.crc;
            default: begin
                if (beat_reg < BEAT_IDX_W'(IN_FRAME_BYTES)) begin
                    sel_byte = frame.echo[beat_reg[$clog2(IN_FRAME_BYTES)-1:0]];
                end else begin
                    sel_byte = 8'h00;
                end
            end
        endcase
    end

    always_comb begin
        beat_next  = beat_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            beat_next  = (beat_reg == BEAT_LAST) ? '0 : beat_reg + 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            beat_reg  <= beat_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            channel_reg <= (beat_reg >= BEAT_HDR0) ? CH_CONV : CH_ECHO;
            byte_reg    <= sel_byte;
            end_reg     <= (beat_reg == BEAT_LAST);
        end
    end

    assign m_valid     = valid_reg;
    assign m_channel   = channel_reg;
    assign m_out_byte  = byte_reg;
    assign m_frame_end = end_reg;

endmodule

[design/sync_frame_check_and_rewrite.sv]
// Sync frame checker and rewriter.
// Input channel (s_valid/s_ready/s_rx_byte): one received byte per beat. A byte
// with bit 7 set starts a new 5-byte frame; other bytes fill the frame and are
// ignored while no frame is open. On the fifth byte the frame is checked: the
// XOR of bytes 0..3, masked to 7 bits, must equal byte 4. Failing frames vanish.
// Output channel (m_valid/m_ready/m_channel/m_out_byte/m_frame_end): a passing
// frame yields a run of 10 beats - the 5 input bytes on channel 0, then
// FF, 02, 14, X, CRC-8 on channel 1, with m_frame_end set on the tenth beat.
// The frame's last byte pushes the checked frame into the queue; the sequencer
// then loads each result beat into the output register. Throughput: one
// result beat per cycle while m_ready is high and a frame is queued, set by the
// single output register. A two-frame queue sits between the frame assembler
// and the beat sequencer; s_ready drops only while that queue is full, and a
// stall on m_ready holds the current beat and backs up into the queue.
// Reset (aresetn low, synchronous): drop any partial frame, empty the queue,
// clear m_valid and wait for a sync byte.
module sync_frame_check_and_rewrite
    import sfcr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_channel,
    output logic [7:0] m_out_byte,
    output logic       m_frame_end
);

    sfcr_push_t  push;
    sfcr_frame_t head;
    logic        q_full;
    logic        q_not_empty;
    logic        pop;

    // Accept bytes whenever the queue has room for a finished frame
    assign s_ready = !q_full;

    sfcr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (s_valid && s_ready),
        .rx_byte  (s_rx_byte),
        .push_out (push)
    );

    sfcr_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_in   (push),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (head)
    );

    // Walk each queued frame out as ten beats
    sfcr_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .frame_avail (q_not_empty),
        .frame       (head),
        .pop         (pop),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_channel   (m_channel),
        .m_out_byte  (m_out_byte),
        .m_frame_end (m_frame_end)
    );

endmodule

[design/sfcr_checker.sv]
module sfcr_checker
    import sfcr_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_rx_byte,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_channel,
    input logic [7:0] m_out_byte,
    input logic       m_frame_end
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_channel)
            && $stable(m_frame_end))
        else $error("result beat changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    a_end_on_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_channel == CH_CONV)
        else $error("run end flagged on echo beat");

    a_run_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_frame_end |=> !m_valid || m_channel == CH_ECHO)
        else $error("new run does not start with echo beat");

    a_conv_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_channel == CH_CONV && !m_frame_end
            |=> m_valid && m_channel == CH_CONV)
        else $error("converted frame broken up");

endmodule

bind sync_frame_check_and_rewrite sfcr_checker u_sfcr_checker (.*);

[bench/sfcr_checker.sv]
module sfcr_scoreboard
    import sfcr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_channel,
    input  logic [7:0] m_out_byte,
    input  logic       m_frame_end,
    output int         err_count,
    output int         pending_beats
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic       channel;
        logic [7:0] data;
        logic       last;
    } result_beat_t;

    result_beat_t awaited_beats[$];

    // Own copy of the frame assembler state
    logic [7:0] rx_frame [IN_FRAME_BYTES];
    int unsigned held_bytes;
    logic        in_frame;

    // Bit-serial CRC-8 over the four leading converted bytes
    function automatic logic [7:0] conv_frame_crc(input logic [31:0] msg);
        logic [7:0] c;
        logic       fb;
        c = CRC_INIT;
        for (int i = 31; i >= 0; i--) begin
            fb = c[7] ^ msg[i];
            c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic void queue_beat(input logic ch, input logic [7:0] d, input logic e);
        result_beat_t b;
        b.channel = ch;
        b.data    = d;
        b.last    = e;
        awaited_beats.push_back(b);
    endfunction

    // Advance the assembler by one received byte and queue any result run
    function automatic void absorb_rx_byte(input logic [7:0] b);
        logic [7:0] chk;
        logic [7:0] conv_x;
        logic [7:0] crc;
        if ((b & SYNC_BIT) != 8'h00) begin
            rx_frame[0] = b;
            held_bytes  = 1;
            in_frame    = 1'b1;
            return;
        end
        if (!in_frame || held_bytes >= IN_FRAME_BYTES) begin
            return;
        end
        rx_frame[held_bytes] = b;
        held_bytes++;
        if (held_bytes < IN_FRAME_BYTES) begin
            return;
        end
        held_bytes = 0;
        in_frame   = 1'b0;
        chk = 8'h00;
        for (int i = 0; i < IN_FRAME_BYTES - 1; i++) begin
            chk ^= rx_frame[i];
        end
        chk &= CHECK_MASK;
        if (chk != rx_frame[IN_FRAME_BYTES-1]) begin
            return;
        end
        conv_x = 8'(({8'h00, rx_frame[2]} << 7) | {8'h00, rx_frame[3]});
        crc    = conv_frame_crc({HDR0, HDR1, HDR2, conv_x});
        for (int i = 0; i < IN_FRAME_BYTES; i++) begin
            queue_beat(CH_ECHO, rx_frame[i], 1'b0);
        end
        queue_beat(CH_CONV, HDR0, 1'b0);
        queue_beat(CH_CONV, HDR1, 1'b0);
        queue_beat(CH_CONV, HDR2, 1'b0);
        queue_beat(CH_CONV, conv_x, 1'b0);
        queue_beat(CH_CONV, crc, 1'b1);
    endfunction

    always @(posedge aclk) begin
        result_beat_t want;
        if (!aresetn) begin
            held_bytes = 0;
            in_frame   = 1'b0;
            err_count  = 0;
            awaited_beats.delete();
        end else begin
            // Compare first: a beat accepted now cannot stem from this edge's input
            if (m_valid && m_ready) begin
                if (awaited_beats.size() == 0) begin
                    $display("%t: unexpected beat ch=%0d byte=%02h end=%0d", $time,
                             m_channel, m_out_byte, m_frame_end);
                    err_count++;
                end else begin
                    want = awaited_beats.pop_front();
                    if (m_channel !== want.channel) begin
                        $display("%t: channel expected %0d actual %0d", $time,
                                 want.channel, m_channel);
                        err_count++;
                    end
                    if (m_out_byte !== want.data) begin
                        $display("%t: out_byte expected %02h actual %02h", $time,
                                 want.data, m_out_byte);
                        err_count++;
                    end
                    if (m_frame_end !== want.last) begin
                        $display("%t: frame_end expected %0d actual %0d", $time,
                                 want.last, m_frame_end);
                        err_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                absorb_rx_byte(s_rx_byte);
            end
        end
        pending_beats = awaited_beats.size();
    end

endmodule

[bench/tb_sync_frame_check_and_rewrite.sv]
module tb_sync_frame_check_and_rewrite;
    timeunit 1ns;
    timeprecision 1ps;
    import sfcr_pkg::*;

    localparam int FRAME_ITEM_TARGET = 410;
    localparam int IDLE_PCT          = 29;
    localparam int HOLD_OFF_CYCLES   = 300;
    localparam int STEADY_CYCLES     = 400;
    localparam int DRAIN_CYCLES      = 20;
    localparam int CYCLE_LIMIT       = 200000;

    logic       aclk;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte   = 8'h00;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic       m_channel;
    logic [7:0] m_out_byte;
    logic       m_frame_end;

    int err_count;
    int pending_beats;
    int sent_count  = 0;   // beats accepted on the input side
    int cycle_count = 0;
    logic steady_send = 1'b0;

    sync_frame_check_and_rewrite dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_channel   (m_channel),
        .m_out_byte  (m_out_byte),
        .m_frame_end (m_frame_end)
    );

    sfcr_scoreboard checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_channel     (m_channel),
        .m_out_byte    (m_out_byte),
        .m_frame_end   (m_frame_end),
        .err_count     (err_count),
        .pending_beats (pending_beats)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Kill a hung run: no correct run comes anywhere near this
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offer one byte; idle first at random unless a steady stretch is on.
    // Valid stays high between back-to-back beats, so only drop it when idling.
    task automatic send_byte(input logic [7:0] b);
        while (!steady_send && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        // Hold the beat until the edge that sees ready high
        do @(posedge aclk); while (!s_ready);
        sent_count++;
    endtask

    // Send sync plus three data bytes and a check byte; corrupt the check if asked.
    // Flip only within the low seven bits so a bad check never looks like a sync.
    task automatic send_frame(input logic [7:0] sync_b, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3,
                              input logic good);
        logic [7:0] chk;
        chk = (sync_b ^ b1 ^ b2 ^ b3) & CHECK_MASK;
        if (!good) begin
            chk ^= 8'(1 << $urandom_range(0, 6));
        end
        send_byte(sync_b);
        send_byte(b1);
        send_byte(b2);
        send_byte(b3);
        send_byte(chk);
    endtask

    function automatic logic [7:0] rand_data();
        return 8'($urandom_range(0, 127));
    endfunction

    function automatic logic [7:0] rand_sync();
        return SYNC_BIT | 8'($urandom_range(0, 127));
    endfunction

    // Stimulus side
    initial begin
        int pick;
        int n;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: data bytes while waiting for sync are ignored
        send_byte(8'h7F);
        send_byte(8'h00);
        // Smallest sync with all-zero data: check byte zero
        send_frame(8'h80, 8'h00, 8'h00, 8'h00, 1'b1);
        // Largest sync with all-ones data: conversion byte goes to FF
        send_frame(8'hFF, 8'h7F, 8'h7F, 8'h7F, 1'b1);
        // Sync byte mid-frame: drop the partial frame and restart on the new sync
        send_byte(8'h85);
        send_byte(8'h11);
        send_frame(8'h9A, 8'h01, 8'h02, 8'h03, 1'b1);
        // Failing check: frame vanishes silently
        send_frame(8'hC3, 8'h10, 8'h20, 8'h30, 1'b0);
        // Data after a full frame is ignored until the next sync
        send_byte(8'h55);

        // Random: mostly well-formed frames, some broken ones and some noise
        while (sent_count < FRAME_ITEM_TARGET) begin
            steady_send = (sent_count >= 200 && sent_count < 280);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_frame(rand_sync(), rand_data(), rand_data(), rand_data(), 1'b1);
                // Trailing data bytes after a full frame
                n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0;
                repeat (n) send_byte(rand_data());
            end else if (pick < 80) begin
                send_frame(rand_sync(), rand_data(), rand_data(), rand_data(), 1'b0);
            end else if (pick < 90) begin
                // Truncated frame: the next sync cuts it short
                send_byte(rand_sync());
                n = $urandom_range(0, 3);
                repeat (n) send_byte(rand_data());
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end
        end
        steady_send = 1'b0;
        s_valid <= 1'b0;

        // Let the checker see the last input beat, then drain every awaited result
        @(posedge aclk);
        while (pending_beats != 0) @(posedge aclk);
        // Catch any stray beat after the last expected one
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Receiver side: random stalls, one long hold-off so the block backs up
    // into its frame queue and stalls the input, then a steady stretch.
    initial begin
        while (!aresetn) @(posedge aclk);
        while (sent_count < 60) begin
            m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            @(posedge aclk);
        end
        m_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge aclk);
        m_ready <= 1'b1;
        repeat (STEADY_CYCLES) @(posedge aclk);
        forever begin
            m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            @(posedge aclk);
        end
    end

endmodule
